[hw/rtl/assert_macros.svh]
// Assertion macros for the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/rws_pkg.sv]
// Shared constants and types for the roulette wheel selection block.
package rws_pkg;

  localparam int FIT_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int IDX_OUT_W = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PROD  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_MUL   = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

[hw/rtl/rws_store.sv]
// Fitness store: one write port and one registered read port.
module rws_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [rws_pkg::FIT_W-1:0]  wdata,
  input  logic [AW-1:0]              raddr,
  output logic [rws_pkg::FIT_W-1:0]  rdata
);
  import rws_pkg::*;

  logic [FIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/rws_mul.sv]
// Serial multiplier: wide unsigned word times a Q0.16 fraction, 16 bits a cycle.
module rws_mul #(
  parameter int SH_W = 41
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [SH_W-1:0]            mcand,
  input  logic [rws_pkg::FRAC_W-1:0] frac,
  output logic                       done,
  output logic [SH_W-1:0]            product
);
  import rws_pkg::*;

  localparam int NCH   = (SH_W + FRAC_W - 1) / FRAC_W;
  localparam int PAD_W = NCH * FRAC_W;
  localparam int ACC_W = PAD_W + FRAC_W;
  localparam int CW    = $clog2(NCH + 1);

  logic [PAD_W-1:0]  sreg;
  logic [ACC_W-1:0]  acc;
  logic [FRAC_W-1:0] fr;
  logic [CW-1:0]     cnt;
  logic [2*FRAC_W-1:0] pp;

  // Chunks go in from the most significant end, so the accumulator shifts up.
  assign pp = sreg[PAD_W-1 -: FRAC_W] * fr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NCH);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sreg <= PAD_W'(mcand);
      fr   <= frac;
      acc  <= '0;
    end else if (cnt != '0) begin
      sreg <= sreg << FRAC_W;
      acc  <= (acc << FRAC_W) + ACC_W'(pp);
    end
  end

  assign product = acc[SH_W+FRAC_W-1:FRAC_W];

endmodule

[hw/rtl/roulette_wheel_select_top.sv]
// Roulette wheel selection: usage notes below.
//
// Input channel (in_valid/in_stall) carries one word: operation, start_new_set,
// fitness (signed Q16.16) and random_fraction (Q0.16). A load word stores one
// fitness in load order; start_new_set empties the set first.
// Loads beyond MAX_ENTRIES are dropped and raise the overflow flag of later draws.
// A draw word forms the shifted sum (total minus count times minimum), scales it
// by the fraction in a serial 16-bit multiplier, then walks the store one entry
// per cycle through its registered read port, subtracting each shifted fitness.
// The store walk stops early at the chosen entry, and an empty draw skips the
// multiplier and the walk. The next word can be taken in the cycle in which
// the result word appears. in_stall is high while a draw is in progress.
// Output channel (out_valid/out_stall) returns selected_index, set_empty and
// overflow from an output register; loads are still taken while a result word
// waits for the receiver. Synchronous reset empties the set and drops any
// pending result.
module roulette_wheel_select_top #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic                          start_new_set,
  input  logic signed [rws_pkg::FIT_W-1:0] fitness,
  input  logic [rws_pkg::FRAC_W-1:0]    random_fraction,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rws_pkg::IDX_OUT_W-1:0] selected_index,
  output logic                          set_empty,
  output logic                          overflow
);
  import rws_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int TOT_W = FIT_W + CNT_W;
  localparam int SH_W  = TOT_W;
  localparam int REM_W = SH_W + 1;

  state_t state;

  logic [CNT_W-1:0]        count;
  logic signed [FIT_W-1:0] minimum;
  logic signed [TOT_W-1:0] total;
  logic                    ovf_seen;

  logic [FRAC_W-1:0]       frac;
  logic signed [CNT_W+FIT_W:0] prod;
  logic signed [TOT_W:0]   shifted_full;
  logic                    mul_done;
  logic [SH_W-1:0]         target;

  logic signed [REM_W-1:0] rem;
  logic signed [REM_W-1:0] rem_next;
  logic signed [FIT_W:0]   diff;
  logic [CNT_W-1:0]        issue_idx;
  logic [IDX_W-1:0]        walk_idx;
  logic                    rvalid;
  logic [FIT_W-1:0]        rdata;
  logic                    walk_end;

  logic [IDX_W-1:0]        sel;
  logic                    sel_empty;

  logic                    in_acc;
  logic                    load_acc;
  logic                    draw_acc;
  logic [CNT_W-1:0]        count_eff;
  logic                    store_we;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && (operation == OP_LOAD);
  assign draw_acc = in_acc && (operation == OP_DRAW);

  assign count_eff = start_new_set ? '0 : count;
  assign store_we  = load_acc && (count_eff < CNT_W'(MAX_ENTRIES));

  rws_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_eff[IDX_W-1:0]),
    .wdata (fitness),
    .raddr (issue_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign shifted_full = {total[TOT_W-1], total} - prod;

  rws_mul #(
    .SH_W (SH_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_SHIFT),
    .mcand   (shifted_full[SH_W-1:0]),
    .frac    (frac),
    .done    (mul_done),
    .product (target)
  );

  // Each step removes the entry's distance above the set minimum.
  assign diff     = $signed({rdata[FIT_W-1], rdata}) - $signed({minimum[FIT_W-1], minimum});
  assign rem_next = rem - {{(REM_W-FIT_W-1){diff[FIT_W]}}, diff};
  assign walk_end = rvalid && (rem_next[REM_W-1] || (rem_next == '0) ||
                    (CNT_W'(walk_idx) == CNT_W'(count - 1'b1)));

  // Set bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      minimum  <= '0;
      total    <= '0;
      ovf_seen <= 1'b0;
    end else if (load_acc) begin
      if (count_eff >= CNT_W'(MAX_ENTRIES)) begin
        ovf_seen <= 1'b1;
      end else begin
        // The first entry of a set always becomes the minimum.
        if (count_eff == '0 || fitness < minimum) begin
          minimum <= fitness;
        end
        total    <= (start_new_set ? '0 : total) + {{CNT_W{fitness[FIT_W-1]}}, fitness};
        count    <= count_eff + 1'b1;
        ovf_seen <= start_new_set ? 1'b0 : ovf_seen;
      end
    end
  end

  // Draw sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rvalid    <= 1'b0;
      issue_idx <= '0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (draw_acc) begin
            state <= (count == '0) ? S_DONE : S_PROD;
          end
        end
        S_PROD:  state <= S_SHIFT;
        S_SHIFT: state <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            state     <= S_WALK;
            issue_idx <= '0;
            rvalid    <= 1'b0;
          end
        end
        S_WALK: begin
          if (walk_end) begin
            state  <= S_DONE;
            rvalid <= 1'b0;
          end else begin
            rvalid <= (issue_idx < count);
            if (issue_idx < count) begin
              issue_idx <= issue_idx + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (draw_acc) begin
      frac      <= random_fraction;
      sel       <= '0;
      sel_empty <= (count == '0);
    end
    if (state == S_PROD) begin
      prod <= $signed({1'b0, count}) * minimum;
    end
    if (state == S_MUL && mul_done) begin
      rem <= $signed({1'b0, target});
    end
    if (state == S_WALK) begin
      walk_idx <= issue_idx[IDX_W-1:0];
      if (rvalid) begin
        rem <= rem_next;
      end
      if (walk_end) begin
        sel <= walk_idx;
      end
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      selected_index <= IDX_OUT_W'(sel);
      set_empty      <= sel_empty;
      overflow       <= ovf_seen;
    end
  end

endmodule

[hw/rtl/rws_checker.sv]
// Port-level checker for the roulette wheel selection block, with its bind.
`include "assert_macros.svh"

module rws_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          operation,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rws_pkg::IDX_OUT_W-1:0] selected_index,
  input logic                          set_empty
);
  import rws_pkg::*;

  // A word held by the receiver stays put.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(selected_index))

  // An empty set always answers with the first index.
  `ASSERT_IMPLIES(a_empty_idx, clk, rst, out_valid && set_empty, selected_index == '0)

  // A draw keeps the block busy for at least the next cycle.
  `ASSERT_NEXT(a_draw_busy, clk, rst, in_valid && !in_stall && (operation == OP_DRAW), in_stall)

  // A load never produces a result word.
  `ASSERT_NEXT(a_load_quiet, clk, rst,
    in_valid && !in_stall && (operation == OP_LOAD) && !out_valid, !out_valid)

endmodule

bind roulette_wheel_select_top rws_checker u_rws_checker (.*);

[test/wheel_pick_checker.sv]
// Checker for the roulette wheel block: predicts each selection and compares result words.
module wheel_pick_checker #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             operation,
  input  logic                             start_new_set,
  input  logic signed [rws_pkg::FIT_W-1:0] fitness,
  input  logic [rws_pkg::FRAC_W-1:0]       random_fraction,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [rws_pkg::IDX_OUT_W-1:0]    selected_index,
  input  logic                             set_empty,
  input  logic                             overflow,
  input  logic                             end_of_run,
  output int                               error_count,
  output int                               pending_count
);
  import rws_pkg::*;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic                 empty;
    logic                 dropped;
  } pick_t;

  // Shadow copy of the stored set.
  logic signed [FIT_W-1:0]   wheel [MAX_ENTRIES];
  int unsigned               entries;
  logic signed [FIT_W-1:0]   floor_fit;
  logic signed [FIT_W+7:0]   total_fit;
  bit                        load_dropped;

  pick_t picks_due[$];
  int    mismatches = 0;
  int    waiting = 0;
  bit    leftovers_checked = 1'b0;

  assign error_count   = mismatches;
  assign pending_count = waiting;

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_set();
    entries      = 0;
    floor_fit    = '0;
    total_fit    = '0;
    load_dropped = 1'b0;
  endtask

  task automatic store_load(logic start, logic signed [FIT_W-1:0] fit);
    if (start) begin
      clear_set();
    end
    if (entries >= MAX_ENTRIES) begin
      load_dropped = 1'b1;
      return;
    end
    wheel[entries] = fit;
    if (entries == 0 || fit < floor_fit) begin
      floor_fit = fit;
    end
    total_fit += fit;
    entries++;
  endtask

  // Scale the shifted sum by the fraction, then spend it entry by entry.
  function automatic pick_t predict_pick(logic [FRAC_W-1:0] frac);
    longint spread;
    longint remaining;
    int     idx;
    pick_t  p;
    p.dropped = load_dropped;
    p.empty   = (entries == 0);
    idx       = 0;
    if (entries != 0) begin
      spread    = longint'(total_fit) - longint'(entries) * longint'(floor_fit);
      remaining = (spread * longint'(frac)) >>> 16;
      idx       = entries - 1;
      for (int i = 0; i < entries; i++) begin
        remaining -= longint'(wheel[i]) - longint'(floor_fit);
        if (remaining <= 0) begin
          idx = i;
          break;
        end
      end
    end
    p.index = idx[IDX_OUT_W-1:0];
    return p;
  endfunction

  always @(posedge clk) begin
    pick_t due;
    if (rst) begin
      clear_set();
      picks_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (picks_due.size() == 0) begin
          report_mismatch($sformatf("result word (index %0d) with no draw waiting",
                                    selected_index));
        end else begin
          due = picks_due.pop_front();
          if (selected_index !== due.index) begin
            report_mismatch($sformatf("selected_index got %0d, expected %0d",
                                      selected_index, due.index));
          end
          if (set_empty !== due.empty) begin
            report_mismatch($sformatf("set_empty got %b, expected %b", set_empty, due.empty));
          end
          if (overflow !== due.dropped) begin
            report_mismatch($sformatf("overflow got %b, expected %b", overflow, due.dropped));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (operation == OP_DRAW) begin
          picks_due = {picks_due, predict_pick(random_fraction)};
        end else begin
          store_load(start_new_set, fitness);
        end
      end
      if (end_of_run && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (picks_due.size() != 0) begin
          report_mismatch($sformatf("%0d draw results never arrived", picks_due.size()));
        end
      end
    end
    waiting = picks_due.size();
  end

endmodule

[test/roulette_wheel_select_top_tb.sv]
// Testbench top for the roulette wheel block: stimulus, output back-pressure and verdict.
module roulette_wheel_select_top_tb;
  import rws_pkg::*;

  localparam int MAX_ENTRIES = 256;
  localparam int LONG_HOLD   = 600;
  localparam int DRAIN_WAIT  = 300;
  localparam int ITEM_TARGET = 1900;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    operation = OP_LOAD;
  logic                    start_new_set = 1'b0;
  logic signed [FIT_W-1:0] fitness = '0;
  logic [FRAC_W-1:0]       random_fraction = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [IDX_OUT_W-1:0]    selected_index;
  logic                    set_empty;
  logic                    overflow;
  logic                    end_of_run = 1'b0;
  int                      error_count;
  int                      pending_count;

  int burst_left = 0;
  int words_sent = 0;
  int draws_sent = 0;
  int sets_built = 0;
  int full_sets = 0;
  int results_seen = 0;
  bit long_hold_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  roulette_wheel_select_top #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .start_new_set   (start_new_set),
    .fitness         (fitness),
    .random_fraction (random_fraction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .selected_index  (selected_index),
    .set_empty       (set_empty),
    .overflow        (overflow)
  );

  wheel_pick_checker #(.MAX_ENTRIES(MAX_ENTRIES)) pick_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .start_new_set   (start_new_set),
    .fitness         (fitness),
    .random_fraction (random_fraction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .selected_index  (selected_index),
    .set_empty       (set_empty),
    .overflow        (overflow),
    .end_of_run      (end_of_run),
    .error_count     (error_count),
    .pending_count   (pending_count)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
    end
  end

  // Offers one word and waits for the edge that takes it. Between bursts the valid
  // is lowered and held low before the task returns, so it is never lowered and raised at once.
  task automatic send_word(logic op, logic start, logic signed [FIT_W-1:0] fit,
                           logic [FRAC_W-1:0] frac, bit last_word = 1'b0);
    int gap;
    in_valid        <= 1'b1;
    operation       <= op;
    start_new_set   <= start;
    fitness         <= fit;
    random_fraction <= frac;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (op == OP_DRAW) begin
      draws_sent++;
    end
    if (last_word) begin
      in_valid <= 1'b0;
    end else if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int                      set_size;
    int                      draw_count;
    int                      mode;
    logic signed [FIT_W-1:0] base;
    logic signed [FIT_W-1:0] fit;
    logic [FRAC_W-1:0]       frac;
    logic                    restart;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Draw before anything is loaded.
    send_word(OP_DRAW, 1'b0, $urandom, 16'hFFFF);

    // Field extremes in one set, with the lowest and highest fractions.
    send_word(OP_LOAD, 1'b1, 32'sh7FFF_FFFF, 16'($urandom_range(0, 65535)));
    send_word(OP_LOAD, 1'b0, 32'sh8000_0000, 16'($urandom_range(0, 65535)));
    send_word(OP_LOAD, 1'b0, 32'sh0000_0000, 16'($urandom_range(0, 65535)));
    send_word(OP_LOAD, 1'b0, 32'sh0000_0001, 16'($urandom_range(0, 65535)));
    send_word(OP_DRAW, 1'b0, $urandom, 16'h0000);
    send_word(OP_DRAW, 1'b0, $urandom, 16'hFFFF);
    send_word(OP_DRAW, 1'b0, $urandom, 16'h8000);
    // A start flag on a draw must leave the set alone.
    send_word(OP_DRAW, 1'b1, $urandom, 16'hC000);
    send_word(OP_DRAW, 1'b0, $urandom, 16'h4000);

    // Equal fitness everywhere gives a shifted sum of zero.
    send_word(OP_LOAD, 1'b1, 32'sh0005_0000, 16'($urandom_range(0, 65535)));
    send_word(OP_LOAD, 1'b0, 32'sh0005_0000, 16'($urandom_range(0, 65535)));
    send_word(OP_LOAD, 1'b0, 32'sh0005_0000, 16'($urandom_range(0, 65535)));
    send_word(OP_DRAW, 1'b0, $urandom, 16'hFFFF);

    // Single entry, then an all-negative set.
    send_word(OP_LOAD, 1'b1, 32'shFFFF_FFFF, 16'($urandom_range(0, 65535)));
    send_word(OP_DRAW, 1'b0, $urandom, 16'h1234);
    send_word(OP_LOAD, 1'b1, -32'sd100000, 16'($urandom_range(0, 65535)));
    send_word(OP_LOAD, 1'b0, -32'sd300000, 16'($urandom_range(0, 65535)));
    send_word(OP_LOAD, 1'b0, -32'sd200000, 16'($urandom_range(0, 65535)));
    send_word(OP_DRAW, 1'b0, $urandom, 16'hFFFF);
    send_word(OP_DRAW, 1'b0, $urandom, 16'h0001);

    while (words_sent < ITEM_TARGET) begin
      mode = $urandom_range(0, 4);
      base = $urandom;
      // Two sets fill the store; the first one also overruns it.
      if (sets_built == 12 || sets_built == 48) begin
        set_size = MAX_ENTRIES + ((full_sets == 0) ? 3 : 0);
        full_sets++;
      end else if ($urandom_range(0, 3) == 0) begin
        set_size = $urandom_range(11, 64);
      end else begin
        set_size = $urandom_range(1, 10);
      end
      // Now and then the new entries extend the previous set instead.
      restart = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < set_size; i++) begin
        case (mode)
          0: fit = $urandom;
          1: fit = $urandom_range(0, 32'h0010_0000);
          2: fit = -32'sd1 - $urandom_range(0, 32'h0008_0000);
          3: fit = base;
          default: begin
            case ($urandom_range(0, 3))
              0: fit = 32'sh7FFF_FFFF;
              1: fit = 32'sh8000_0000;
              2: fit = '0;
              default: fit = $urandom;
            endcase
          end
        endcase
        send_word(OP_LOAD,
                  (i == 0) ? restart
                           : (set_size < MAX_ENTRIES && $urandom_range(0, 63) == 0),
                  fit, 16'($urandom_range(0, 65535)));
        if (set_size < MAX_ENTRIES && $urandom_range(0, 6) == 0) begin
          send_word(OP_DRAW, 1'($urandom_range(0, 1)), $urandom,
                    16'($urandom_range(0, 65535)));
        end
      end
      draw_count = $urandom_range(1, 6);
      repeat (draw_count) begin
        case ($urandom_range(0, 7))
          0: frac = '0;
          1: frac = '1;
          default: frac = 16'($urandom_range(0, 65535));
        endcase
        send_word(OP_DRAW, 1'($urandom_range(0, 1)), $urandom, frac);
      end
      sets_built++;
    end
    send_word(OP_DRAW, 1'b0, $urandom, 16'($urandom_range(0, 65535)), 1'b1);

    // Let the checker see the last draw before looking at its queue.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d words (%0d draws) over %0d random sets; %0d sets filled the store.",
             words_sent, draws_sent, sets_built, full_sets);
    $display("%0d result words taken, including one %0d-cycle receiver hold-off.",
             results_seen, LONG_HOLD);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver back-pressure: free-running stretches, random stalls, mostly-stalled
  // stretches, and once a long hold-off that backs the block up into its input.
  initial begin
    int span;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 30) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span = $urandom_range(1, 60);
        case ($urandom_range(0, 2))
          0: begin
            out_stall <= 1'b0;
            repeat (span) @(posedge clk);
          end
          1: begin
            repeat (span) begin
              out_stall <= ($urandom_range(0, 1) == 1);
              @(posedge clk);
            end
          end
          default: begin
            repeat (span) begin
              out_stall <= ($urandom_range(0, 3) != 0);
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  initial begin
    #(12 * 5000000);
    $display("Timeout: the run did not finish in time.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
